// ===== src/mkte_pkg.sv =====
// mkte_pkg: shared types, codes and character tables for the multi-tap keypad text entry core
// no dependencies; imported by every module of the block but mkte_ram
package mkte_pkg;

    // defaults for the top level parameters
    localparam int TEXT_DEPTH_DEF = 512;
    localparam int MAX_RUN_DEF    = 32;

    // fixed field widths
    localparam int CMD_W    = 2;
    localparam int KEY_W    = 4;
    localparam int ACT_W    = 3;
    localparam int CHAR_W   = 7;
    localparam int LEN_W    = 10;
    localparam int RUN_W    = 6;
    localparam int MAXLEN_W = 10;
    localparam int ROW_W    = 5 * CHAR_W;

    localparam logic [MAXLEN_W-1:0] MAX_LEN_RESET = 10'd512;

    // input commands
    localparam logic [CMD_W-1:0] CMD_KEY       = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GROUP_END = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESTART   = 2'd2;

    // key codes
    localparam logic [KEY_W-1:0] KEY_NINE   = 4'd9;
    localparam logic [KEY_W-1:0] KEY_STAR   = 4'd10;
    localparam logic [KEY_W-1:0] KEY_HASH   = 4'd11;
    localparam logic [KEY_W-1:0] KEY_LETTER = 4'd12;

    // keys after a double star
    localparam logic [KEY_W-1:0] SEL_BACKSPACE = 4'd2;
    localparam logic [KEY_W-1:0] SEL_LOWER     = 4'd5;
    localparam logic [KEY_W-1:0] SEL_NUMERIC   = 4'd6;
    localparam logic [KEY_W-1:0] SEL_SYMBOL    = 4'd7;
    localparam logic [KEY_W-1:0] SEL_UPPER     = 4'd8;
    localparam logic [KEY_W-1:0] SEL_WORD_DEL  = 4'd9;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_UC_A  = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_UC_Z  = 7'h5a;
    localparam logic [CHAR_W-1:0] CASE_DIFF  = 7'h20;

    typedef enum logic [1:0] {
        MODE_LOWER   = 2'd0,
        MODE_UPPER   = 2'd1,
        MODE_NUMERIC = 2'd2,
        MODE_SYMBOL  = 2'd3
    } t_mode;

    typedef enum logic [ACT_W-1:0] {
        ACT_APPEND    = 3'd0,
        ACT_REMOVE    = 3'd1,
        ACT_TRUNCATE  = 3'd2,
        ACT_READ_BACK = 3'd3,
        ACT_FINISHED  = 3'd4
    } t_action;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_CLOSE,
        ST_RUN,
        ST_APPEND,
        ST_FINISH,
        ST_CONT,
        ST_POST,
        ST_WD_INIT,
        ST_WD_SKIP,
        ST_WD_WORD,
        ST_WD_EMIT,
        ST_FLUSH
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic restart;
        logic hit;
        logic close;
        logic open_run;
        logic clr_armed;
        logic set_mode;
        logic append;
        logic finish;
        logic backspace;
        logic read_back;
        logic p_load;
        logic p_dec;
        logic wd_commit;
        logic wd_emit;
        logic flush;
    } t_ctrl;

    // datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] in_cmd;
        logic [KEY_W-1:0] in_key;
        logic             run_open;
        logic             run_match;
        logic             run_digit;
        logic             run_more;
        logic             armed;
        logic             done;
        logic             full;
        logic             lim_next;
        logic             count_zero;
        logic             p_zero;
        logic             rd_space;
        logic             emit_ok;
        logic             pend_valid;
        logic             out_free;
    } t_status;

    typedef struct packed {
        logic [2:0]       len;
        logic [ROW_W-1:0] chars;   // entry 0 in the low bits
    } t_row;

    // remainder of a 6-bit value by a small length, by shifted subtraction
    function automatic logic [2:0] mod_small(input logic [RUN_W-1:0] v, input logic [2:0] len);
        logic [8:0] r;
        logic [8:0] m;
        r = 9'(v);
        for (int s = 4; s >= 0; s--) begin
            m = 9'(len) << s;
            if (r >= m) begin
                r = r - m;
            end
        end
        return r[2:0];
    endfunction

    // character rows: alpha " ,.?0" "!:;#1" "ABC2" .. "WXYZ9", symbol "=0" "<([{1" "@$&%2" ..
    function automatic t_row tab_row(input logic sym, input logic [KEY_W-1:0] key);
        t_row row;
        row = '{len: 3'd1, chars: '0};
        if (sym) begin
            case (key)
                4'd0: row = '{len: 3'd2, chars: {7'h00, 7'h00, 7'h00, 7'h30, 7'h3d}};
                4'd1: row = '{len: 3'd5, chars: {7'h31, 7'h7b, 7'h5b, 7'h28, 7'h3c}};
                4'd2: row = '{len: 3'd5, chars: {7'h32, 7'h25, 7'h26, 7'h24, 7'h40}};
                4'd3: row = '{len: 3'd5, chars: {7'h33, 7'h7d, 7'h5d, 7'h29, 7'h3e}};
                4'd4: row = '{len: 3'd5, chars: {7'h34, 7'h2f, 7'h2a, 7'h2d, 7'h2b}};
                4'd5: row = '{len: 3'd3, chars: {7'h00, 7'h00, 7'h35, 7'h60, 7'h27}};
                4'd6: row = '{len: 3'd2, chars: {7'h00, 7'h00, 7'h00, 7'h36, 7'h22}};
                4'd7: row = '{len: 3'd2, chars: {7'h00, 7'h00, 7'h00, 7'h37, 7'h5e}};
                4'd8: row = '{len: 3'd3, chars: {7'h00, 7'h00, 7'h38, 7'h7c, 7'h5c}};
                4'd9: row = '{len: 3'd3, chars: {7'h00, 7'h00, 7'h39, 7'h7e, 7'h5f}};
                default: row = '{len: 3'd1, chars: '0};
            endcase
        end else begin
            case (key)
                4'd0: row = '{len: 3'd5, chars: {7'h30, 7'h3f, 7'h2e, 7'h2c, 7'h20}};
                4'd1: row = '{len: 3'd5, chars: {7'h31, 7'h23, 7'h3b, 7'h3a, 7'h21}};
                4'd2: row = '{len: 3'd4, chars: {7'h00, 7'h32, 7'h43, 7'h42, 7'h41}};
                4'd3: row = '{len: 3'd4, chars: {7'h00, 7'h33, 7'h46, 7'h45, 7'h44}};
                4'd4: row = '{len: 3'd4, chars: {7'h00, 7'h34, 7'h49, 7'h48, 7'h47}};
                4'd5: row = '{len: 3'd4, chars: {7'h00, 7'h35, 7'h4c, 7'h4b, 7'h4a}};
                4'd6: row = '{len: 3'd4, chars: {7'h00, 7'h36, 7'h4f, 7'h4e, 7'h4d}};
                4'd7: row = '{len: 3'd5, chars: {7'h37, 7'h53, 7'h52, 7'h51, 7'h50}};
                4'd8: row = '{len: 3'd4, chars: {7'h00, 7'h38, 7'h56, 7'h55, 7'h54}};
                4'd9: row = '{len: 3'd5, chars: {7'h39, 7'h5a, 7'h59, 7'h58, 7'h57}};
                default: row = '{len: 3'd1, chars: '0};
            endcase
        end
        return row;
    endfunction

    // character produced when a digit run of h presses closes
    function automatic logic [CHAR_W-1:0] close_char(input t_mode mode,
                                                     input logic [KEY_W-1:0] key,
                                                     input logic [RUN_W-1:0] h);
        t_row              row;
        logic [2:0]        idx;
        logic [CHAR_W-1:0] c;
        row = tab_row(mode == MODE_SYMBOL, key);
        idx = mod_small(h - RUN_W'(1), row.len);
        c   = row.chars[idx*CHAR_W +: CHAR_W];
        if (mode == MODE_NUMERIC) begin
            c = CHAR_ZERO + CHAR_W'(key);
        end else if (mode == MODE_LOWER && c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
            c = c + CASE_DIFF;
        end
        return c;
    endfunction

endpackage

// ===== src/multitap_keypad_text_entry_core.sv =====
// Multi-tap keypad text entry core.
// Slave stream: one decoded keypad event per transaction, tuser = command
// (key press, group end, restart), tdata = key code. Master stream: result
// transactions, tuser = action, tdata = character code and stored text length,
// tlast marks the last result caused by one input transaction; an input may
// cause no result at all.
// Configuration: i_cfg_wr_en writes the length limit (10 bits).
// Items are handled one at a time. Closing a numeric run of h presses runs
// the append loop, which writes one character per pass. Word delete scans the
// text store backwards one entry per cycle through its registered read port.
// Results leave through a holding register and an output register, so a
// stalled receiver only holds the sequencer when both are full. Reset clears
// all control state, empties the text, selects numeric mode and sets the
// length limit to 512; the text store needs no clearing.
// depends on mkte_pkg, mkte_ctrl, mkte_dpath, mkte_ram
module multitap_keypad_text_entry_core
    import mkte_pkg::*;
#(
    parameter int TEXT_DEPTH = TEXT_DEPTH_DEF,
    parameter int MAX_RUN    = MAX_RUN_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // [3:0] key, [7:4] zero
    input  logic [CMD_W-1:0]    s_axis_tuser,   // [1:0] cmd
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [23:0]         m_axis_tdata,   // [6:0] char_code, [16:7] text_length, [23:17] zero
    output logic [ACT_W-1:0]    m_axis_tuser,   // [2:0] action
    output logic                m_axis_tlast,
    input  logic                i_cfg_wr_en,
    input  logic [MAXLEN_W-1:0] i_cfg_wr_data
);

    t_ctrl             w_ctrl;
    t_status           w_status;
    logic [CHAR_W-1:0] w_out_char;
    logic [LEN_W-1:0]  w_out_len;

    mkte_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_ctrl     (w_ctrl)
    );

    mkte_dpath #(
        .TEXT_DEPTH (TEXT_DEPTH),
        .MAX_RUN    (MAX_RUN)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (w_ctrl),
        .o_status      (w_status),
        .i_in_cmd      (s_axis_tuser),
        .i_in_key      (s_axis_tdata[KEY_W-1:0]),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_out_action  (m_axis_tuser),
        .o_out_char    (w_out_char),
        .o_out_len     (w_out_len),
        .o_out_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {7'd0, w_out_len, w_out_char};

endmodule

// ===== src/mkte_ram.sv =====
// mkte_ram: generic simple dual-port RAM, one write port and one registered read port
// no dependencies
module mkte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/mkte_dpath.sv =====
// mkte_dpath: entry state registers, text store, result holding register and output register
// depends on mkte_pkg and mkte_ram; driven by mkte_ctrl
module mkte_dpath
    import mkte_pkg::*;
#(
    parameter int TEXT_DEPTH = TEXT_DEPTH_DEF,
    parameter int MAX_RUN    = MAX_RUN_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_ctrl               i_ctrl,
    output t_status             o_status,
    input  logic [CMD_W-1:0]    i_in_cmd,
    input  logic [KEY_W-1:0]    i_in_key,
    input  logic                i_cfg_wr_en,
    input  logic [MAXLEN_W-1:0] i_cfg_wr_data,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [ACT_W-1:0]    o_out_action,
    output logic [CHAR_W-1:0]   o_out_char,
    output logic [LEN_W-1:0]    o_out_len,
    output logic                o_out_last
);

    localparam int AW = $clog2(TEXT_DEPTH);
    localparam int CW = $clog2(TEXT_DEPTH + 1);
    localparam int LW = ((CW > MAXLEN_W) ? CW : MAXLEN_W) + 1;

    logic [CMD_W-1:0]    r_in_cmd;
    logic [KEY_W-1:0]    r_in_key;
    logic [CW-1:0]       r_count, n_count;
    t_mode               r_mode;
    logic [KEY_W-1:0]    r_run_key;
    logic [RUN_W-1:0]    r_run_hits;
    logic                r_run_open;
    logic                r_armed;
    logic                r_done;
    logic [MAXLEN_W-1:0] r_max_len;
    logic [CHAR_W-1:0]   r_char;
    logic [RUN_W-1:0]    r_reps;
    logic [RUN_W-1:0]    r_cnt;
    logic [CW-1:0]       r_p;

    logic                r_pend_valid;
    t_action             r_pend_action;
    logic [CHAR_W-1:0]   r_pend_char;
    logic [LEN_W-1:0]    r_pend_len;

    logic                r_out_valid;
    t_action             r_out_action;
    logic [CHAR_W-1:0]   r_out_char;
    logic [LEN_W-1:0]    r_out_len;
    logic                r_out_last;

    logic [RUN_W-1:0]    w_hits;
    logic [CW-1:0]       w_count_m1;
    logic [CW-1:0]       w_p_m1;
    logic [AW-1:0]       w_rd_addr;
    logic [CHAR_W-1:0]   w_rd_data;
    logic                w_space;
    logic [LW-1:0]       w_lim;
    logic [LW-1:0]       w_count_p1;
    logic                w_emit;
    logic                w_out_free;
    t_action             w_action;

    assign w_hits     = (r_run_hits == '0) ? RUN_W'(1) : r_run_hits;
    assign w_count_m1 = r_count - CW'(1);
    assign w_p_m1     = r_p - CW'(1);
    // look one entry ahead so each scan step has its data on the next cycle
    assign w_rd_addr  = i_ctrl.p_load ? w_count_m1[AW-1:0] : w_p_m1[AW-1:0];
    assign w_space    = (w_rd_data == CHAR_SPACE);

    assign w_lim      = (LW'(r_max_len) > LW'(TEXT_DEPTH)) ? LW'(TEXT_DEPTH) : LW'(r_max_len);
    assign w_count_p1 = LW'(r_count) + LW'(1);

    mkte_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (TEXT_DEPTH)
    ) u_text_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_ctrl.append),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (r_char),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_comb begin
        n_count = r_count;
        if (i_ctrl.restart) begin
            n_count = '0;
        end else if (i_ctrl.append) begin
            n_count = r_count + CW'(1);
        end else if (i_ctrl.backspace && r_count != '0) begin
            n_count = w_count_m1;
        end else if (i_ctrl.wd_commit) begin
            n_count = r_p + CW'(w_space);
        end
    end

    assign w_emit = i_ctrl.append | i_ctrl.finish | i_ctrl.backspace
                  | i_ctrl.read_back | i_ctrl.wd_emit;

    always_comb begin
        w_action = ACT_APPEND;
        if (i_ctrl.finish) begin
            w_action = ACT_FINISHED;
        end else if (i_ctrl.backspace) begin
            w_action = ACT_REMOVE;
        end else if (i_ctrl.wd_emit) begin
            w_action = ACT_TRUNCATE;
        end else if (i_ctrl.read_back) begin
            w_action = ACT_READ_BACK;
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    // entry state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_mode     <= MODE_NUMERIC;
            r_run_key  <= '0;
            r_run_hits <= '0;
            r_run_open <= 1'b0;
            r_armed    <= 1'b0;
            r_done     <= 1'b0;
            r_max_len  <= MAX_LEN_RESET;
        end else begin
            r_count <= n_count;
            if (i_cfg_wr_en) begin
                r_max_len <= i_cfg_wr_data;
            end
            if (i_ctrl.restart) begin
                r_mode     <= MODE_NUMERIC;
                r_run_key  <= '0;
                r_run_hits <= '0;
                r_run_open <= 1'b0;
                r_armed    <= 1'b0;
                r_done     <= 1'b0;
            end else begin
                if (i_ctrl.hit && r_run_hits < RUN_W'(MAX_RUN)) begin
                    r_run_hits <= r_run_hits + RUN_W'(1);
                end
                if (i_ctrl.close) begin
                    r_run_open <= 1'b0;
                    if (r_run_key == KEY_STAR && w_hits == RUN_W'(2)) begin
                        r_armed <= 1'b1;
                    end
                end
                if (i_ctrl.open_run) begin
                    r_run_key  <= r_in_key;
                    r_run_hits <= RUN_W'(1);
                    r_run_open <= 1'b1;
                end
                if (i_ctrl.clr_armed) begin
                    r_armed <= 1'b0;
                end
                if (i_ctrl.set_mode) begin
                    case (r_in_key)
                        SEL_LOWER:   r_mode <= MODE_LOWER;
                        SEL_NUMERIC: r_mode <= MODE_NUMERIC;
                        SEL_SYMBOL:  r_mode <= MODE_SYMBOL;
                        SEL_UPPER:   r_mode <= MODE_UPPER;
                        default:     r_mode <= r_mode;
                    endcase
                end
                if (i_ctrl.finish) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_in_cmd <= i_in_cmd;
            r_in_key <= i_in_key;
        end
        if (i_ctrl.close) begin
            r_char <= close_char(r_mode, r_run_key, w_hits);
            r_reps <= (r_mode == MODE_NUMERIC) ? w_hits : RUN_W'(1);
            r_cnt  <= '0;
        end else if (i_ctrl.append) begin
            r_cnt <= r_cnt + RUN_W'(1);
        end
        if (i_ctrl.p_load) begin
            r_p <= w_count_m1;
        end else if (i_ctrl.p_dec) begin
            r_p <= w_p_m1;
        end
    end

    // one result is held back so the last one of an item can be marked
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_emit) begin
                r_pend_valid <= 1'b1;
            end else if (i_ctrl.flush) begin
                r_pend_valid <= 1'b0;
            end
            if ((w_emit && r_pend_valid) || i_ctrl.flush) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_pend_action <= w_action;
            r_pend_char   <= i_ctrl.append ? r_char : '0;
            r_pend_len    <= LEN_W'(n_count);
        end
        if ((w_emit && r_pend_valid) || i_ctrl.flush) begin
            r_out_action <= r_pend_action;
            r_out_char   <= r_pend_char;
            r_out_len    <= r_pend_len;
            r_out_last   <= i_ctrl.flush;
        end
    end

    assign o_status = '{
        in_cmd:     r_in_cmd,
        in_key:     r_in_key,
        run_open:   r_run_open,
        run_match:  (r_run_key == r_in_key),
        run_digit:  (r_run_key <= KEY_NINE),
        run_more:   (r_cnt < r_reps),
        armed:      r_armed,
        done:       r_done,
        full:       (r_count >= CW'(TEXT_DEPTH)),
        lim_next:   (w_count_p1 >= w_lim),
        count_zero: (r_count == '0),
        p_zero:     (r_p == '0),
        rd_space:   w_space,
        emit_ok:    (!r_pend_valid || w_out_free),
        pend_valid: r_pend_valid,
        out_free:   w_out_free
    };

    assign o_out_valid  = r_out_valid;
    assign o_out_action = r_out_action;
    assign o_out_char   = r_out_char;
    assign o_out_len    = r_out_len;
    assign o_out_last   = r_out_last;

endmodule

// ===== src/mkte_ctrl.sv =====
// mkte_ctrl: sequencing state machine for one keypad transaction at a time
// depends on mkte_pkg; commands mkte_dpath
module mkte_ctrl
    import mkte_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_ctrl   o_ctrl
);

    t_state r_state, n_state;
    logic   w_sel_taken;

    // keys that a double star turns into a selector action
    assign w_sel_taken = i_status.armed &&
        (i_status.in_key == SEL_BACKSPACE || i_status.in_key == SEL_LOWER ||
         i_status.in_key == SEL_NUMERIC || i_status.in_key == SEL_SYMBOL ||
         i_status.in_key == SEL_UPPER || i_status.in_key == SEL_WORD_DEL ||
         i_status.in_key == KEY_HASH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_ctrl     = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctrl.capture = 1'b1;
                    n_state        = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (i_status.in_cmd)
                    CMD_RESTART: begin
                        o_ctrl.restart = 1'b1;
                        n_state        = ST_FLUSH;
                    end
                    CMD_KEY: begin
                        if (i_status.done) begin
                            n_state = ST_FLUSH;
                        end else if (i_status.run_open && i_status.run_match) begin
                            o_ctrl.hit = 1'b1;
                            n_state    = ST_FLUSH;
                        end else begin
                            n_state = ST_CLOSE;
                        end
                    end
                    CMD_GROUP_END: begin
                        n_state = i_status.done ? ST_FLUSH : ST_CLOSE;
                    end
                    default: n_state = ST_FLUSH;
                endcase
            end
            ST_CLOSE: begin
                if (!i_status.run_open) begin
                    n_state = ST_CONT;
                end else begin
                    o_ctrl.close = 1'b1;
                    n_state      = i_status.run_digit ? ST_RUN : ST_CONT;
                end
            end
            ST_RUN: begin
                n_state = i_status.run_more ? ST_APPEND : ST_CONT;
            end
            ST_APPEND: begin
                if (i_status.emit_ok) begin
                    if (i_status.full) begin
                        n_state = ST_FINISH;
                    end else begin
                        o_ctrl.append = 1'b1;
                        n_state       = i_status.lim_next ? ST_FINISH : ST_RUN;
                    end
                end
            end
            ST_FINISH: begin
                if (i_status.emit_ok) begin
                    o_ctrl.finish = 1'b1;
                    n_state       = ST_FLUSH;
                end
            end
            ST_CONT: begin
                if (i_status.in_cmd == CMD_KEY) begin
                    n_state = ST_POST;
                end else begin
                    o_ctrl.clr_armed = 1'b1;
                    n_state          = ST_FLUSH;
                end
            end
            ST_POST: begin
                if (i_status.emit_ok) begin
                    o_ctrl.clr_armed = 1'b1;
                    n_state          = ST_FLUSH;
                    if (w_sel_taken) begin
                        case (i_status.in_key)
                            SEL_BACKSPACE: o_ctrl.backspace = 1'b1;
                            SEL_WORD_DEL:  n_state = ST_WD_INIT;
                            KEY_HASH:      o_ctrl.read_back = 1'b1;
                            default:       o_ctrl.set_mode = 1'b1;
                        endcase
                    end else if (i_status.in_key == KEY_HASH) begin
                        n_state = ST_FINISH;
                    end else if (i_status.in_key < KEY_LETTER) begin
                        o_ctrl.open_run = 1'b1;
                    end
                end
            end
            ST_WD_INIT: begin
                if (i_status.count_zero) begin
                    n_state = ST_WD_EMIT;
                end else begin
                    o_ctrl.p_load = 1'b1;
                    n_state       = ST_WD_SKIP;
                end
            end
            // walk back over trailing spaces
            ST_WD_SKIP: begin
                if (!i_status.p_zero && i_status.rd_space) begin
                    o_ctrl.p_dec = 1'b1;
                end else if (!i_status.p_zero) begin
                    o_ctrl.p_dec = 1'b1;
                    n_state      = ST_WD_WORD;
                end else begin
                    o_ctrl.wd_commit = 1'b1;
                    n_state          = ST_WD_EMIT;
                end
            end
            // walk back over the word itself
            ST_WD_WORD: begin
                if (!i_status.p_zero && !i_status.rd_space) begin
                    o_ctrl.p_dec = 1'b1;
                end else begin
                    o_ctrl.wd_commit = 1'b1;
                    n_state          = ST_WD_EMIT;
                end
            end
            ST_WD_EMIT: begin
                if (i_status.emit_ok) begin
                    o_ctrl.wd_emit = 1'b1;
                    n_state        = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!i_status.pend_valid) begin
                    n_state = ST_IDLE;
                end else if (i_status.out_free) begin
                    o_ctrl.flush = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// ===== src/mkte_checker.sv =====
// mkte_checker: port-level assertions for the keypad text entry core, bound to the top level
// depends on mkte_pkg and multitap_keypad_text_entry_core
module mkte_checker
    import mkte_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [23:0]         m_axis_tdata,
    input logic [ACT_W-1:0]    m_axis_tuser,
    input logic                m_axis_tlast
);

    // one transaction at a time: the sequencer is busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while previous transaction still in work");

    // only appends carry a character
    a_char_only_on_append: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ACT_APPEND |-> m_axis_tdata[CHAR_W-1:0] == '0)
        else $error("character code on a non-append result");

    // nothing follows the finished result within the same transaction
    a_finish_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ACT_FINISHED |-> m_axis_tlast)
        else $error("finished result not marked last");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output changed while stalled");

endmodule

bind multitap_keypad_text_entry_core mkte_checker u_mkte_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking testbench for multitap_keypad_text_entry_core
// keeps its own copy of the text entry state to predict every result transaction
// depends on mkte_pkg and multitap_keypad_text_entry_core
module tb;
    import mkte_pkg::*;

    localparam int TEXT_DEPTH   = TEXT_DEPTH_DEF;
    localparam int MAX_RUN      = MAX_RUN_DEF;
    localparam int DRAIN_CYCLES = 64;
    localparam int LONG_HOLD    = 400;

    // command code the block ignores
    localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] key;
    } key_event_t;

    typedef struct packed {
        t_action           act;
        logic [CHAR_W-1:0] ch;
        logic [LEN_W-1:0]  len;
        logic              last;
    } entry_result_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata = '0;     // [3:0] key, [7:4] zero
    logic [CMD_W-1:0]    s_axis_tuser = '0;     // [1:0] cmd
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [23:0]         m_axis_tdata;          // [6:0] char_code, [16:7] text_length, [23:17] zero
    logic [ACT_W-1:0]    m_axis_tuser;          // [2:0] action
    logic                m_axis_tlast;
    logic                i_cfg_wr_en = 1'b0;
    logic [MAXLEN_W-1:0] i_cfg_wr_data = '0;

    key_event_t    key_events[$];
    entry_result_t entry_results[$];
    int            errors = 0;
    int            events_made = 0;
    int            hold_requests = 0;

    // predictor state
    logic [CHAR_W-1:0] text_mem [TEXT_DEPTH];
    int                text_len;
    t_mode             cur_mode;
    logic [KEY_W-1:0]  run_key;
    int                run_presses;
    bit                run_active;
    bit                star_armed;
    bit                entry_over;
    int                length_limit;
    entry_result_t     held_result;
    bit                held_valid;

    multitap_keypad_text_entry_core #(
        .TEXT_DEPTH(TEXT_DEPTH),
        .MAX_RUN   (MAX_RUN)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic string alpha_row(input int k);
        case (k)
            0: return " ,.?0";
            1: return "!:;#1";
            2: return "ABC2";
            3: return "DEF3";
            4: return "GHI4";
            5: return "JKL5";
            6: return "MNO6";
            7: return "PQRS7";
            8: return "TUV8";
            default: return "WXYZ9";
        endcase
    endfunction

    function automatic string symbol_row(input int k);
        case (k)
            0: return "=0";
            1: return "<([{1";
            2: return "@$&%2";
            3: return ">)]}3";
            4: return "+-*/4";
            5: return "'`5";
            6: return "\"6";
            7: return "^7";
            8: return "\\|8";
            default: return "_~9";
        endcase
    endfunction

    // character picked by a closed alpha or symbol run
    function automatic logic [CHAR_W-1:0] tap_char(input t_mode m, input int k, input int h);
        string row;
        byte   c;
        if (m == MODE_SYMBOL) begin
            row = symbol_row(k);
        end else begin
            row = alpha_row(k);
        end
        c = row[(h - 1) % row.len()];
        if (m == MODE_LOWER && c[6:0] >= CHAR_UC_A && c[6:0] <= CHAR_UC_Z) begin
            c = c + 8'(CASE_DIFF);
        end
        return c[6:0];
    endfunction

    // results of one input are collected one behind, so the last one can get its flag
    task automatic entry_emit(input t_action a, input logic [CHAR_W-1:0] c);
        if (held_valid) begin
            entry_results.push_back(held_result);
        end
        held_result.act  = a;
        held_result.ch   = c;
        held_result.len  = LEN_W'(text_len);
        held_result.last = 1'b0;
        held_valid = 1'b1;
    endtask

    task automatic entry_finish();
        entry_over = 1'b1;
        entry_emit(ACT_FINISHED, '0);
    endtask

    task automatic entry_append(input logic [CHAR_W-1:0] c);
        int lim;
        lim = (length_limit > TEXT_DEPTH) ? TEXT_DEPTH : length_limit;
        if (text_len >= TEXT_DEPTH) begin
            entry_finish();
            return;
        end
        text_mem[text_len] = c;
        text_len++;
        entry_emit(ACT_APPEND, c);
        if (text_len >= lim) begin
            entry_finish();
        end
    endtask

    task automatic entry_close_run();
        int h;
        if (!run_active) begin
            return;
        end
        run_active = 1'b0;
        h = (run_presses < 1) ? 1 : run_presses;
        if (run_key == KEY_STAR) begin
            if (h == 2) begin
                star_armed = 1'b1;
            end
            return;
        end
        if (run_key > KEY_NINE) begin
            return;
        end
        if (cur_mode == MODE_NUMERIC) begin
            for (int i = 0; i < h && !entry_over; i++) begin
                entry_append(CHAR_ZERO + CHAR_W'(run_key));
            end
        end else begin
            entry_append(tap_char(cur_mode, run_key, h));
        end
    endtask

    task automatic entry_word_delete();
        int p;
        if (text_len > 0) begin
            p = text_len - 1;
            while (p > 0 && text_mem[p] == CHAR_SPACE) p--;
            while (p > 0 && text_mem[p] != CHAR_SPACE) p--;
            if (text_mem[p] == CHAR_SPACE) begin
                p++;
            end
            text_len = p;
        end
        entry_emit(ACT_TRUNCATE, '0);
    endtask

    task automatic entry_double_star(input logic [KEY_W-1:0] k, output bit taken);
        taken = 1'b1;
        case (k)
            SEL_BACKSPACE: begin
                if (text_len > 0) begin
                    text_len--;
                end
                entry_emit(ACT_REMOVE, '0);
            end
            SEL_LOWER:    cur_mode = MODE_LOWER;
            SEL_NUMERIC:  cur_mode = MODE_NUMERIC;
            SEL_SYMBOL:   cur_mode = MODE_SYMBOL;
            SEL_UPPER:    cur_mode = MODE_UPPER;
            SEL_WORD_DEL: entry_word_delete();
            KEY_HASH:     entry_emit(ACT_READ_BACK, '0);
            default:      taken = 1'b0;
        endcase
    endtask

    task automatic entry_press(input logic [KEY_W-1:0] k);
        bit taken;
        if (run_active && run_key == k) begin
            if (run_presses < MAX_RUN) begin
                run_presses++;
            end
            return;
        end
        entry_close_run();
        if (entry_over) begin
            return;
        end
        if (star_armed) begin
            star_armed = 1'b0;
            entry_double_star(k, taken);
            if (taken) begin
                return;
            end
        end
        if (k == KEY_HASH) begin
            entry_finish();
            return;
        end
        if (k >= KEY_LETTER) begin
            return;
        end
        run_key     = k;
        run_presses = 1;
        run_active  = 1'b1;
    endtask

    task automatic entry_restart();
        text_len    = 0;
        cur_mode    = MODE_NUMERIC;
        run_key     = '0;
        run_presses = 0;
        run_active  = 1'b0;
        star_armed  = 1'b0;
        entry_over  = 1'b0;
    endtask

    task automatic entry_step(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] k);
        held_valid = 1'b0;
        case (cmd)
            CMD_RESTART: entry_restart();
            CMD_KEY: begin
                if (!entry_over) begin
                    entry_press(k);
                end
            end
            CMD_GROUP_END: begin
                if (!entry_over) begin
                    entry_close_run();
                    star_armed = 1'b0;
                end
            end
            default: ;
        endcase
        if (held_valid) begin
            held_result.last = 1'b1;
            entry_results.push_back(held_result);
            held_valid = 1'b0;
        end
    endtask

    // driver: bursts of transactions with random gaps
    key_event_t next_event;
    int         send_burst = 1;
    int         send_gap = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                entry_step(s_axis_tuser, s_axis_tdata[KEY_W-1:0]);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (key_events.size() > 0) begin
                    next_event = key_events.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= next_event.cmd;
                    s_axis_tdata  <= {4'h0, next_event.key};
                    send_burst--;
                    if (send_burst <= 0) begin
                        send_burst = $urandom_range(1, 12);
                        case ($urandom_range(0, 7))
                            0, 1:    send_gap = 0;
                            7:       send_gap = $urandom_range(20, 40);
                            default: send_gap = $urandom_range(1, 8);
                        endcase
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each result transaction and runs its own stall pattern
    entry_result_t want;
    int            rx_cycle = 0;
    int            hold_served = 0;
    int            hold_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (entry_results.size() == 0) begin
                    $display("%0t: unexpected result: expected none, got action %0d char %02h len %0d",
                             $time, m_axis_tuser, m_axis_tdata[6:0], m_axis_tdata[16:7]);
                    errors++;
                end else begin
                    want = entry_results.pop_front();
                    if (m_axis_tuser !== want.act) begin
                        $display("%0t: action: expected %0d, got %0d",
                                 $time, want.act, m_axis_tuser);
                        errors++;
                    end
                    if (m_axis_tdata[6:0] !== want.ch) begin
                        $display("%0t: char_code: expected %02h, got %02h",
                                 $time, want.ch, m_axis_tdata[6:0]);
                        errors++;
                    end
                    if (m_axis_tdata[16:7] !== want.len) begin
                        $display("%0t: text_length: expected %0d, got %0d",
                                 $time, want.len, m_axis_tdata[16:7]);
                        errors++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $display("%0t: tlast: expected %0b, got %0b",
                                 $time, want.last, m_axis_tlast);
                        errors++;
                    end
                end
            end
            rx_cycle++;
            if (hold_served < hold_requests) begin
                hold_served++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                case ((rx_cycle / 97) % 4)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
                    2:       m_axis_tready <= (rx_cycle % 3 == 0);
                    default: m_axis_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    task automatic push_event(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] k);
        key_event_t e;
        e.cmd = cmd;
        e.key = k;
        key_events.push_back(e);
        if (cmd != CMD_UNKNOWN) begin
            events_made++;
        end
    endtask

    task automatic press(input logic [KEY_W-1:0] k, input int n);
        repeat (n) push_event(CMD_KEY, k);
    endtask

    task automatic write_limit(input int v);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= MAXLEN_W'(v);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        length_limit = v;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (key_events.size() > 0 || s_axis_tvalid || entry_results.size() > 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // mostly well formed runs and double star commands, with some noise
    task automatic gen_random(input int n_items, input int restart_pct);
        int               goal;
        int               pick;
        logic [KEY_W-1:0] sk;
        goal = events_made + n_items;
        while (events_made < goal) begin
            if ($urandom_range(0, 99) < restart_pct) begin
                push_event(CMD_RESTART, KEY_W'($urandom_range(0, 15)));
            end
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                press(KEY_W'($urandom_range(0, 9)),
                      ($urandom_range(0, 15) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 6));
                if ($urandom_range(0, 1) == 1) begin
                    push_event(CMD_GROUP_END, KEY_W'($urandom_range(0, 15)));
                end
            end else if (pick < 70) begin
                press(KEY_STAR, 2);
                case ($urandom_range(0, 6))
                    0:       sk = SEL_BACKSPACE;
                    1:       sk = SEL_LOWER;
                    2:       sk = SEL_NUMERIC;
                    3:       sk = SEL_SYMBOL;
                    4:       sk = SEL_UPPER;
                    5:       sk = SEL_WORD_DEL;
                    default: sk = KEY_HASH;
                endcase
                press(sk, 1);
            end else if (pick < 75) begin
                press(KEY_HASH, 1);
                push_event(CMD_RESTART, KEY_W'($urandom_range(0, 15)));
            end else if (pick < 90) begin
                push_event(CMD_W'($urandom_range(0, 3)), KEY_W'($urandom_range(0, 15)));
            end else begin
                press(KEY_STAR, ($urandom_range(0, 1) == 1) ? 1 : 3);
                if ($urandom_range(0, 1) == 1) begin
                    push_event(CMD_GROUP_END, KEY_W'($urandom_range(0, 15)));
                end else begin
                    press(KEY_W'($urandom_range(12, 15)), 1);
                end
            end
        end
    endtask

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        entry_restart();
        length_limit = int'(MAX_LEN_RESET);
        held_valid   = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // numeric runs, then each mode and each double star command
        press(0, 1);
        press(9, 2);
        push_event(CMD_GROUP_END, 4'hf);
        press(KEY_STAR, 2);
        press(SEL_LOWER, 1);
        press(2, 3);
        press(0, 1);
        press(4'd15, 1);                 // a letter closes the run and does nothing else
        press(KEY_STAR, 2);
        press(SEL_UPPER, 1);
        press(7, 4);
        push_event(CMD_GROUP_END, 4'h0);
        press(KEY_STAR, 2);
        press(SEL_SYMBOL, 1);
        press(1, 6);
        push_event(CMD_GROUP_END, 4'h0);
        press(KEY_STAR, 2);
        press(SEL_WORD_DEL, 1);
        press(KEY_STAR, 2);
        press(SEL_BACKSPACE, 1);
        press(KEY_STAR, 2);
        press(KEY_HASH, 1);
        // triple star, star dropped at group end, star dropped by a plain digit
        press(KEY_STAR, 3);
        push_event(CMD_GROUP_END, 4'h0);
        press(KEY_STAR, 2);
        push_event(CMD_GROUP_END, 4'h0);
        press(KEY_STAR, 2);
        press(3, 1);
        push_event(CMD_GROUP_END, 4'h0);
        push_event(CMD_UNKNOWN, 4'hf);
        press(KEY_STAR, 2);
        press(SEL_NUMERIC, 1);
        // commands on empty text
        push_event(CMD_RESTART, 4'h0);
        press(KEY_STAR, 2);
        press(SEL_BACKSPACE, 1);
        press(KEY_STAR, 2);
        press(SEL_WORD_DEL, 1);
        // lone hash finishes; everything after it is dropped until restart
        press(5, 1);
        press(KEY_HASH, 1);
        press(1, 1);
        push_event(CMD_GROUP_END, 4'h0);
        push_event(CMD_RESTART, 4'h0);
        wait_drained();

        write_limit(1);
        gen_random(15, 40);
        wait_drained();

        write_limit(9);
        gen_random(35, 20);
        hold_requests++;
        wait_drained();

        // limit lowered below the stored length takes effect at the next append
        write_limit(512);
        push_event(CMD_RESTART, 4'h0);
        press(4, 6);
        push_event(CMD_GROUP_END, 4'h0);
        wait_drained();
        write_limit(3);
        press(1, 1);
        push_event(CMD_GROUP_END, 4'h0);
        push_event(CMD_RESTART, 4'h0);
        wait_drained();

        // saturated run that ends exactly at the limit
        write_limit(32);
        press(8, 36);
        push_event(CMD_GROUP_END, 4'h0);
        push_event(CMD_RESTART, 4'h0);
        wait_drained();

        write_limit(40);
        gen_random(40, 10);
        wait_drained();

        write_limit(512);
        gen_random(50, 6);
        hold_requests++;
        wait_drained();

        if (errors == 0 && entry_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== multitap_keypad_text_entry_core.f =====
src/mkte_pkg.sv
src/mkte_ram.sv
src/mkte_dpath.sv
src/mkte_ctrl.sv
src/multitap_keypad_text_entry_core.sv
src/mkte_checker.sv
test/tb.sv
